// File: rtl/sphere_frustum_cull_defines.svh
// Assertion macros for the sphere frustum cull checker
`ifndef SPHERE_FRUSTUM_CULL_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define SFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sphere_frustum_cull: port check failed");

// next-cycle implication, quiet while in reset
`define SFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sphere_frustum_cull: port check failed");

// next-cycle implication, checked through reset as well
`define SFC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("sphere_frustum_cull: reset check failed");

`endif

// File: rtl/sfc_pkg.sv
// Constants and types shared by the sphere frustum cull modules
`timescale 1ns / 1ps
package sfc_pkg;

  localparam int NUM_PLANES     = 6;
  localparam int PLANE_BITS     = 64;
  localparam int NORMAL_BITS    = 14;
  localparam int OFFSET_BITS    = 22;
  localparam int FRAC_BITS      = 12;
  localparam int NX_LSB         = 0;
  localparam int NY_LSB         = 14;
  localparam int NZ_LSB         = 28;
  localparam int D_LSB          = 42;
  localparam int CFG_IDX_BITS   = 3;
  localparam int OUT_BITS       = 24;
  localparam int QUEUE_DEPTH    = 8;
  localparam int INDEX_BITS_DEF = 24;
  localparam int COORD_BITS_DEF = 22;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } sfc_reg_e;

endpackage

// File: rtl/sfc_fifo.sv
// Result index queue between the test pipeline and the output stage
`timescale 1ns / 1ps
module sfc_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [sfc_pkg::OUT_BITS-1:0] data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output logic [sfc_pkg::OUT_BITS-1:0] data_o
);
  import sfc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [OUT_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// File: rtl/sfc_front.sv
// Sphere intake, index assignment and six-plane distance test pipeline
`timescale 1ns / 1ps
module sfc_front #(
  parameter int INDEX_BITS = sfc_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_BITS-1:0]     center_x_i,
  input  logic signed [COORD_BITS-1:0]     center_y_i,
  input  logic signed [COORD_BITS-1:0]     center_z_i,
  input  logic [COORD_BITS-2:0]            radius_i,
  input  logic                             frame_start_i,
  input  logic                             cfg_valid_i,
  input  logic [sfc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [sfc_pkg::PLANE_BITS-1:0]   cfg_data_i,
  input  logic                             pop_i,
  output logic                             push_o,
  output logic [sfc_pkg::OUT_BITS-1:0]     push_index_o
);
  import sfc_pkg::*;

  localparam int PROD_W = NORMAL_BITS + COORD_BITS;
  localparam int DR_W   = ((OFFSET_BITS > COORD_BITS) ? OFFSET_BITS : COORD_BITS) + 1;
  localparam int SUM_W  = ((PROD_W > DR_W + FRAC_BITS) ? PROD_W : DR_W + FRAC_BITS) + 2;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  logic [PLANE_BITS-1:0] plane_q [NUM_PLANES];

  logic                  accept;
  logic                  drop;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [INDEX_BITS-1:0] next_q, next_d;
  logic [INDEX_BITS-1:0] cur;
  logic [OUT_BITS-1:0]   cur_out;

  logic                         v1_q;
  logic signed [COORD_BITS-1:0] cx1_q, cy1_q, cz1_q;
  logic [COORD_BITS-2:0]        r1_q;
  logic [OUT_BITS-1:0]          idx1_q;

  logic                     v2_q;
  logic signed [PROD_W-1:0] px2_q [NUM_PLANES];
  logic signed [PROD_W-1:0] py2_q [NUM_PLANES];
  logic signed [PROD_W-1:0] pz2_q [NUM_PLANES];
  logic signed [DR_W-1:0]   dr2_q [NUM_PLANES];
  logic signed [PROD_W-1:0] px2_d [NUM_PLANES];
  logic signed [PROD_W-1:0] py2_d [NUM_PLANES];
  logic signed [PROD_W-1:0] pz2_d [NUM_PLANES];
  logic signed [DR_W-1:0]   dr2_d [NUM_PLANES];
  logic [OUT_BITS-1:0]      idx2_q;

  logic                    v3_q;
  logic signed [SUM_W-1:0] a3_q [NUM_PLANES];
  logic signed [SUM_W-1:0] b3_q [NUM_PLANES];
  logic signed [SUM_W-1:0] a3_d [NUM_PLANES];
  logic signed [SUM_W-1:0] b3_d [NUM_PLANES];
  logic [OUT_BITS-1:0]     idx3_q;

  logic                    v4_q;
  logic                    cull4_q, cull4_d;
  logic [OUT_BITS-1:0]     idx4_q;
  logic signed [SUM_W-1:0] plane_dist [NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        plane_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PLANE_LEFT:   plane_q[0] <= cfg_data_i;
        REG_PLANE_RIGHT:  plane_q[1] <= cfg_data_i;
        REG_PLANE_BOTTOM: plane_q[2] <= cfg_data_i;
        REG_PLANE_TOP:    plane_q[3] <= cfg_data_i;
        REG_PLANE_NEAR:   plane_q[4] <= cfg_data_i;
        REG_PLANE_FAR:    plane_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (cnt_q < CNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = v4_q && !cull4_q;
  assign drop       = v4_q && cull4_q;
  assign push_index_o = idx4_q;

  assign cur    = frame_start_i ? '0 : next_q;
  assign next_d = (cur == IDX_MAX) ? IDX_MAX : cur + 1'b1;
  assign cnt_d  = cnt_q + CNT_W'(accept) - CNT_W'(drop) - CNT_W'(pop_i);

  if (INDEX_BITS >= OUT_BITS) begin : g_idx_trunc
    assign cur_out = cur[OUT_BITS-1:0];
  end else begin : g_idx_ext
    assign cur_out = {{(OUT_BITS - INDEX_BITS){1'b0}}, cur};
  end

  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      px2_d[k] = PROD_W'($signed(plane_q[k][NX_LSB +: NORMAL_BITS])) * PROD_W'(cx1_q);
      py2_d[k] = PROD_W'($signed(plane_q[k][NY_LSB +: NORMAL_BITS])) * PROD_W'(cy1_q);
      pz2_d[k] = PROD_W'($signed(plane_q[k][NZ_LSB +: NORMAL_BITS])) * PROD_W'(cz1_q);
      dr2_d[k] = DR_W'($signed(plane_q[k][D_LSB +: OFFSET_BITS]))
               + DR_W'($signed({1'b0, r1_q}));
      a3_d[k]  = SUM_W'(px2_q[k]) + SUM_W'(py2_q[k]);
      b3_d[k]  = SUM_W'(pz2_q[k]) + (SUM_W'(dr2_q[k]) <<< FRAC_BITS);
      plane_dist[k] = a3_q[k] + b3_q[k];
    end
    cull4_d = 1'b0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      cull4_d = cull4_d | plane_dist[k][SUM_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      next_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        next_q <= next_d;
      end
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx1_q  <= center_x_i;
      cy1_q  <= center_y_i;
      cz1_q  <= center_z_i;
      r1_q   <= radius_i;
      idx1_q <= cur_out;
    end
    for (int k = 0; k < NUM_PLANES; k++) begin
      px2_q[k] <= px2_d[k];
      py2_q[k] <= py2_d[k];
      pz2_q[k] <= pz2_d[k];
      dr2_q[k] <= dr2_d[k];
      a3_q[k]  <= a3_d[k];
      b3_q[k]  <= b3_d[k];
    end
    idx2_q  <= idx1_q;
    idx3_q  <= idx2_q;
    idx4_q  <= idx3_q;
    cull4_q <= cull4_d;
  end

endmodule

// File: rtl/sfc_back.sv
// Output stage that drains the index queue into the result channel
`timescale 1ns / 1ps
module sfc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fifo_valid_i,
  input  logic [sfc_pkg::OUT_BITS-1:0] fifo_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sfc_pkg::OUT_BITS-1:0] block_index_o
);
  import sfc_pkg::*;

  logic                out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0] out_index_q;

  assign pop_o       = fifo_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_index_q <= fifo_data_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign block_index_o = out_index_q;

endmodule

// File: rtl/sphere_frustum_cull.sv
// Top level of the six-plane bounding sphere culler
//
// channel   direction  transfer when            payload
// in        sink       in_valid_i & in_ready_o   center_x/y/z, radius, frame_start
// out       source     out_valid_o & out_ready_i block_index
// cfg       sink       cfg_valid_i & cfg_ready_o cfg_index, cfg_data (always ready)
//
// One sphere per cycle while in_ready_o is high; visible spheres raise out_valid_o.
// Four test stages feed an eight-entry index queue ahead of the output register.
// in_ready_o drops only when eight spheres wait in the test stages and the queue.
// Reset clears planes, frame index, stage valids, queue and output register.
`timescale 1ns / 1ps
module sphere_frustum_cull #(
  parameter int INDEX_BITS = sfc_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_BITS-1:0]     center_x_i,
  input  logic signed [COORD_BITS-1:0]     center_y_i,
  input  logic signed [COORD_BITS-1:0]     center_z_i,
  input  logic [COORD_BITS-2:0]            radius_i,
  input  logic                             frame_start_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sfc_pkg::OUT_BITS-1:0]     block_index_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [sfc_pkg::PLANE_BITS-1:0]   cfg_data_i
);
  import sfc_pkg::*;

  logic                push;
  logic [OUT_BITS-1:0] push_index;
  logic                pop;
  logic                fifo_valid;
  logic [OUT_BITS-1:0] fifo_data;

  assign cfg_ready_o = 1'b1;

  sfc_front #(
    .INDEX_BITS (INDEX_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .center_z_i    (center_z_i),
    .radius_i      (radius_i),
    .frame_start_i (frame_start_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pop_i         (pop),
    .push_o        (push),
    .push_index_o  (push_index)
  );

  sfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_index),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  sfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_valid_i  (fifo_valid),
    .fifo_data_i   (fifo_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .block_index_o (block_index_o)
  );

endmodule

// File: rtl/sfc_checker.sv
// Port-level assertion checker for the sphere frustum culler, with its bind
`timescale 1ns / 1ps
`include "sphere_frustum_cull_defines.svh"
module sfc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [sfc_pkg::OUT_BITS-1:0] block_index_o,
  input logic                         cfg_ready_o
);

  `SFC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(block_index_o))
  `SFC_ASSERT_IMP(a_full_has_out, !in_ready_o, out_valid_o)
  `SFC_ASSERT_RST(a_rst_out_idle, !rst_ni, !out_valid_o)
  `SFC_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_o)

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the six-plane sphere frustum culler
`timescale 1ns / 1ps
module tb_top;
  import sfc_pkg::*;

  localparam int COORD_W    = COORD_BITS_DEF;
  localparam int IDX_W      = INDEX_BITS_DEF;
  localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN  = -(1 << (COORD_W - 1));
  localparam int RADIUS_MAX = COORD_MAX;
  localparam int NORMAL_MAX = (1 << (NORMAL_BITS - 1)) - 1;
  localparam int NORMAL_MIN = -(1 << (NORMAL_BITS - 1));
  localparam int OFFSET_MAX = (1 << (OFFSET_BITS - 1)) - 1;
  localparam int OFFSET_MIN = -(1 << (OFFSET_BITS - 1));
  localparam int Q_ONE      = 1 << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = CFG_IDX_BITS'(NUM_PLANES);
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = CFG_IDX_BITS'(NUM_PLANES + 1);

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned WATCHDOG_MAX  = 2000;
  localparam int unsigned RANDOM_PHASES = 12;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [COORD_W-2:0]        r;
    logic                      fs;
  } sphere_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] center_x_i = '0;
  logic signed [COORD_W-1:0] center_y_i = '0;
  logic signed [COORD_W-1:0] center_z_i = '0;
  logic [COORD_W-2:0]        radius_i = '0;
  logic                      frame_start_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [OUT_BITS-1:0]       block_index_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i = '0;
  logic [PLANE_BITS-1:0]     cfg_data_i = '0;

  sphere_frustum_cull #(
    .INDEX_BITS(IDX_W),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .center_z_i   (center_z_i),
    .radius_i     (radius_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .block_index_o(block_index_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  sphere_t               sphere_queue[$];
  logic [OUT_BITS-1:0]   visible_index_q[$];
  logic [PLANE_BITS-1:0] plane_copy[NUM_PLANES];
  logic [IDX_W-1:0]      frame_index_model;
  logic [IDX_W-1:0]      index_now;
  logic [OUT_BITS-1:0]   index_want;
  sphere_t               next_sphere;

  bit          sphere_xfer = 1'b0;
  bit          cfg_xfer = 1'b0;
  bit          out_xfer = 1'b0;
  bit          no_gaps = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned sender_gap = 0;
  int unsigned sender_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;
  int unsigned rx_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int rand_signed(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned p;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 2) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {OFFSET_BITS'(d), NORMAL_BITS'(nz), NORMAL_BITS'(ny), NORMAL_BITS'(nx)};
  endfunction

  function automatic logic [PLANE_BITS-1:0] rand_plane(int span);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8) return '0;
    if (p < 16) return {$urandom, $urandom};
    if (p < 20) begin
      case ($urandom_range(0, 3))
        0: return pack_plane(NORMAL_MIN, NORMAL_MIN, NORMAL_MIN, OFFSET_MIN);
        1: return pack_plane(NORMAL_MAX, NORMAL_MAX, NORMAL_MAX, OFFSET_MAX);
        2: return '1;
        default: return pack_plane(0, 0, 0, OFFSET_MAX);
      endcase
    end
    return pack_plane(rand_signed(Q_ONE), rand_signed(Q_ONE), rand_signed(Q_ONE),
                      int'($urandom_range(0, span)) - span / 4);
  endfunction

  // scaled test: n.c + d*4096 against -r*4096, per plane
  function automatic bit sphere_in_view(logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy,
                                        logic signed [COORD_W-1:0] cz,
                                        logic [COORD_W-2:0] r);
    longint nx, ny, nz, d, plane_dist, floor_v;
    logic [PLANE_BITS-1:0] p;
    floor_v = -(longint'(r) <<< FRAC_BITS);
    for (int k = 0; k < NUM_PLANES; k++) begin
      p = plane_copy[k];
      nx = longint'($signed(p[NX_LSB +: NORMAL_BITS]));
      ny = longint'($signed(p[NY_LSB +: NORMAL_BITS]));
      nz = longint'($signed(p[NZ_LSB +: NORMAL_BITS]));
      d  = longint'($signed(p[D_LSB +: OFFSET_BITS]));
      plane_dist = nx * longint'(cx) + ny * longint'(cy) + nz * longint'(cz)
                 + (d <<< FRAC_BITS);
      if (plane_dist < floor_v) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(string what, logic [OUT_BITS-1:0] want,
                               logic [OUT_BITS-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic add_sphere(int cx, int cy, int cz, int unsigned r, bit fs);
    sphere_t s;
    s.cx = COORD_W'(cx);
    s.cy = COORD_W'(cy);
    s.cz = COORD_W'(cz);
    s.r  = (COORD_W - 1)'(r);
    s.fs = fs;
    sphere_queue = {sphere_queue, s};
  endtask

  task automatic add_rand_sphere(int span);
    sphere_t s;
    if ($urandom_range(0, 6) == 0) begin
      s.cx = COORD_W'($urandom);
      s.cy = COORD_W'($urandom);
      s.cz = COORD_W'($urandom);
      s.r  = (COORD_W - 1)'($urandom);
    end else begin
      s.cx = COORD_W'(rand_signed(span));
      s.cy = COORD_W'(rand_signed(span));
      s.cz = COORD_W'(rand_signed(span));
      s.r  = (COORD_W - 1)'($urandom_range(0, span / 4));
    end
    s.fs = ($urandom_range(0, 19) == 0);
    sphere_queue = {sphere_queue, s};
  endtask

  task automatic write_plane(logic [CFG_IDX_BITS-1:0] idx, logic [PLANE_BITS-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_xfer) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sphere_queue.size() != 0 || in_valid_i || visible_index_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input transfers, predictor, config shadow, watchdog
  always @(posedge clk_i) begin
    sphere_xfer = rst_ni && in_valid_i && in_ready_o;
    cfg_xfer    = rst_ni && cfg_valid_i && cfg_ready_o;
    if (!rst_ni) begin
      frame_index_model = '0;
      for (int k = 0; k < NUM_PLANES; k++) plane_copy[k] = '0;
    end
    if (cfg_xfer && cfg_index_i < NUM_PLANES) plane_copy[cfg_index_i] = cfg_data_i;
    if (sphere_xfer) begin
      if (frame_start_i) frame_index_model = '0;
      index_now = frame_index_model;
      if (frame_index_model != '1) frame_index_model = frame_index_model + 1'b1;
      if (sphere_in_view(center_x_i, center_y_i, center_z_i, radius_i))
        visible_index_q = {visible_index_q, OUT_BITS'(index_now)};
    end
    if (sphere_xfer || cfg_xfer || (rst_ni && out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sender
  always @(negedge clk_i) begin
    if (sphere_xfer) sender_gap = no_gaps ? 0 : draw_gap(sender_calm);
    if (in_valid_i && !sphere_xfer) begin
      // hold until transfer
    end else if (sender_gap != 0) begin
      sender_gap--;
      in_valid_i <= 1'b0;
    end else if (sphere_queue.size() != 0) begin
      next_sphere = sphere_queue.pop_front();
      center_x_i    <= next_sphere.cx;
      center_y_i    <= next_sphere.cy;
      center_z_i    <= next_sphere.cz;
      radius_i      <= next_sphere.r;
      frame_start_i <= next_sphere.fs;
      in_valid_i    <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      rx_hold = LONG_HOLD;
    end
    if (rx_stall == 0 && (out_xfer || $urandom_range(0, 15) == 0))
      rx_stall = draw_gap(rx_calm);
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_xfer = rst_ni && out_valid_o && out_ready_i;
    if (out_xfer) begin
      if (visible_index_q.size() == 0) begin
        note_mismatch("block_index with none expected", '0, block_index_o);
      end else begin
        index_want = visible_index_q.pop_front();
        if (block_index_o !== index_want)
          note_mismatch("block_index mismatch", index_want, block_index_o);
      end
    end
  end

  initial begin
    int span;
    int unsigned n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all planes zero after reset: everything visible
    add_sphere(0, 0, 0, 0, 1'b1);
    add_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b0);
    add_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0, 1'b0);
    add_sphere(COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX, 1'b0);
    add_sphere(-1, -1, -1, 1, 1'b1);
    wait_idle();

    // axis-aligned box, half width 1000; spare indexes must not land
    write_plane(REG_PLANE_LEFT,   pack_plane(Q_ONE, 0, 0, 1000));
    write_plane(REG_PLANE_RIGHT,  pack_plane(-Q_ONE, 0, 0, 1000));
    write_plane(REG_PLANE_BOTTOM, pack_plane(0, Q_ONE, 0, 1000));
    write_plane(REG_PLANE_TOP,    pack_plane(0, -Q_ONE, 0, 1000));
    write_plane(REG_PLANE_NEAR,   pack_plane(0, 0, Q_ONE, 1000));
    write_plane(REG_PLANE_FAR,    pack_plane(0, 0, -Q_ONE, 1000));
    write_plane(REG_UNUSED_LO, '1);
    write_plane(REG_UNUSED_HI, pack_plane(NORMAL_MIN, NORMAL_MIN, NORMAL_MIN, OFFSET_MIN));
    add_sphere(0, 0, 0, 0, 1'b1);
    add_sphere(-1100, 0, 0, 100, 1'b0);
    add_sphere(-1101, 0, 0, 100, 1'b0);
    add_sphere(1101, 0, 0, 100, 1'b0);
    add_sphere(0, -2000, 0, 10, 1'b0);
    add_sphere(0, 2000, 0, 10, 1'b0);
    add_sphere(0, 0, -2000, 10, 1'b0);
    add_sphere(0, 0, 2000, 10, 1'b0);
    add_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX, 1'b0);
    wait_idle();

    // unnormalized extreme normals and offsets
    write_plane(REG_PLANE_LEFT,   pack_plane(NORMAL_MIN, NORMAL_MIN, NORMAL_MIN, OFFSET_MAX));
    write_plane(REG_PLANE_RIGHT,  '0);
    write_plane(REG_PLANE_BOTTOM, '0);
    write_plane(REG_PLANE_TOP,    '0);
    write_plane(REG_PLANE_NEAR,   '0);
    write_plane(REG_PLANE_FAR,    pack_plane(NORMAL_MAX, NORMAL_MAX, NORMAL_MAX, OFFSET_MIN));
    add_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0, 1'b1);
    add_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0, 1'b0);
    add_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX, 1'b0);
    add_sphere(0, 0, 0, RADIUS_MAX, 1'b0);
    add_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b0);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 4) begin
        // stall the output while the input keeps offering: fill the pipe
        for (int k = 0; k < NUM_PLANES; k++) write_plane(CFG_IDX_BITS'(k), '0);
        no_gaps = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 120; i++) add_sphere(rand_signed(COORD_MAX), rand_signed(COORD_MAX),
                                                 rand_signed(COORD_MAX),
                                                 $urandom_range(0, RADIUS_MAX), i == 0);
        wait_idle();
        no_gaps = 1'b0;
      end
      span = 1 << $urandom_range(8, COORD_W - 1);
      write_plane(REG_PLANE_LEFT,   rand_plane(span));
      write_plane(REG_PLANE_RIGHT,  rand_plane(span));
      write_plane(REG_PLANE_BOTTOM, rand_plane(span));
      write_plane(REG_PLANE_TOP,    rand_plane(span));
      write_plane(REG_PLANE_NEAR,   rand_plane(span));
      write_plane(REG_PLANE_FAR,    rand_plane(span));
      if ($urandom_range(0, 2) == 0)
        write_plane($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, {$urandom, $urandom});
      n = $urandom_range(115, 155);
      for (int i = 0; i < n; i++) add_rand_sphere(span);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
